/* rtl/plr_pkg.sv */
// shared constants and types for the polyline resampler
`timescale 1ns / 1ps

package plr_pkg;

    // coordinate and register widths
    localparam int COORD_W   = 32;
    localparam int RES_W     = 31;

    // reset value of the spacing register, 0.05 in Q15.16
    localparam logic [RES_W-1:0] RES_RESET = RES_W'(3277);

    // default saturation limit for samples per segment
    localparam int MAX_STEPS_DEF = 63;

    // one resampled point handed from the core to the output register
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               eos;
        logic               clip;
    } t_emit;

endpackage

/* rtl/plr_core.sv */
// segment sequencer with one shared shift-add / restoring unit
`timescale 1ns / 1ps

module plr_core
    import plr_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COORD_W-1:0] i_point_x,
    input  logic [COORD_W-1:0] i_point_y,
    input  logic               i_final_point,
    input  logic [RES_W-1:0]   i_res,
    input  logic               i_slot_free,
    output logic               o_idle,
    output t_emit              o_emit
);

    // working widths: difference, square, remainder
    localparam int DW        = COORD_W + 1;
    localparam int ACC_W     = 2 * DW;
    localparam int REM_W     = DW + 3;
    localparam int MUL_STEPS = DW;
    localparam int SQRT_STEPS = DW;
    localparam int CNT_STEPS = DW;
    localparam int DIV_STEPS = ACC_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int CNT_W     = $clog2(MAX_STEPS + 1);

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQX  = 4'd1;
    localparam logic [3:0] ST_SQY  = 4'd2;
    localparam logic [3:0] ST_ADD  = 4'd3;
    localparam logic [3:0] ST_SQRT = 4'd4;
    localparam logic [3:0] ST_CNT  = 4'd5;
    localparam logic [3:0] ST_MULX = 4'd6;
    localparam logic [3:0] ST_DIVX = 4'd7;
    localparam logic [3:0] ST_MULY = 4'd8;
    localparam logic [3:0] ST_DIVY = 4'd9;
    localparam logic [3:0] ST_EMIT = 4'd10;
    localparam logic [3:0] ST_PREV = 4'd11;
    localparam logic [3:0] ST_FIN  = 4'd12;

    // control state
    logic [3:0]        r_state, n_state;
    logic              r_have, n_have;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_j, n_j;

    // payload state
    logic [COORD_W-1:0] r_px, n_px, r_py, n_py, r_cx, n_cx, r_cy, n_cy;
    logic               r_fin, n_fin, r_clip, n_clip;
    logic               r_xneg, n_xneg, r_yneg, n_yneg;
    logic [DW-1:0]      r_ax, n_ax, r_ay, n_ay;
    logic [ACC_W-1:0]   r_acc, n_acc, r_sum, n_sum;
    logic [DW-1:0]      r_mcand, n_mcand, r_root, n_root, r_len, n_len;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]   r_cnt_tot, n_cnt_tot;
    logic [DW-1:0]      r_qx_inc, n_qx_inc, r_rx_inc, n_rx_inc;
    logic [DW-1:0]      r_qy_inc, n_qy_inc, r_ry_inc, n_ry_inc;
    logic [DW-1:0]      r_qx, n_qx, r_rx, n_rx, r_qy, n_qy, r_ry, n_ry;

    // shared unit signals
    logic [DW-1:0]      dx, dy;
    logic [DW:0]        mul_sum;
    logic [ACC_W-1:0]   mul_next;
    logic [REM_W-1:0]   sq_sh, sq_trial, sq_rem;
    logic               sq_ge;
    logic [DW-1:0]      sq_root;
    logic [DW-1:0]      divisor;
    logic [DW:0]        div_sh, div_dif;
    logic               div_ge;
    logic [DW:0]        div_rem;
    logic [ACC_W-1:0]   div_acc;
    logic [DW-1:0]      cnt_q;
    logic               cnt_sat;
    logic [DW:0]        ax_sum, ax_red, ay_sum, ay_red;
    logic               ax_ge, ay_ge;
    logic [COORD_W-1:0] off_x, off_y;
    logic               emit_go, last_j;

    // segment difference at accept
    assign dx = {i_point_x[COORD_W-1], i_point_x} - {r_px[COORD_W-1], r_px};
    assign dy = {i_point_y[COORD_W-1], i_point_y} - {r_py[COORD_W-1], r_py};

    // shift-add multiply step, multiplier in the low half
    assign mul_sum  = {1'b0, r_acc[ACC_W-1:DW]} + (r_acc[0] ? {1'b0, r_mcand} : '0);
    assign mul_next = {mul_sum, r_acc[DW-1:1]};

    // square root digit step, two radicand bits a step
    assign sq_sh    = {r_rem[REM_W-3:0], r_acc[ACC_W-1:ACC_W-2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign sq_rem   = sq_ge ? (sq_sh - sq_trial) : sq_sh;
    assign sq_root  = {r_root[DW-2:0], sq_ge};

    // restoring divide step, dividend shifts out of the top of acc
    assign divisor = (r_state == ST_CNT) ? {{(DW-RES_W){1'b0}}, i_res} : r_len;
    assign div_sh  = {r_rem[DW-1:0], r_acc[ACC_W-1]};
    assign div_dif = div_sh - {1'b0, divisor};
    assign div_ge  = div_sh >= {1'b0, divisor};
    assign div_rem = div_ge ? div_dif : div_sh;
    assign div_acc = {r_acc[ACC_W-2:0], div_ge};
    assign cnt_q   = div_acc[DW-1:0];
    assign cnt_sat = cnt_q > DW'(MAX_STEPS);

    // running quotient and remainder of the sample offsets
    assign ax_sum = {1'b0, r_rx} + {1'b0, r_rx_inc};
    assign ax_red = ax_sum - {1'b0, r_len};
    assign ax_ge  = ax_sum >= {1'b0, r_len};
    assign ay_sum = {1'b0, r_ry} + {1'b0, r_ry_inc};
    assign ay_red = ay_sum - {1'b0, r_len};
    assign ay_ge  = ay_sum >= {1'b0, r_len};

    assign off_x = r_xneg ? (COORD_W'(0) - r_qx[COORD_W-1:0]) : r_qx[COORD_W-1:0];
    assign off_y = r_yneg ? (COORD_W'(0) - r_qy[COORD_W-1:0]) : r_qy[COORD_W-1:0];

    // emitted point
    always_comb begin
        o_emit.valid = 1'b0;
        o_emit.x     = r_px;
        o_emit.y     = r_py;
        o_emit.eos   = 1'b0;
        o_emit.clip  = 1'b0;
        unique case (r_state)
            ST_EMIT: begin
                o_emit.valid = 1'b1;
                o_emit.x     = r_px + off_x;
                o_emit.y     = r_py + off_y;
                o_emit.clip  = r_clip;
            end
            ST_PREV: begin
                o_emit.valid = 1'b1;
            end
            ST_FIN: begin
                o_emit.valid = 1'b1;
                o_emit.x     = r_cx;
                o_emit.y     = r_cy;
                o_emit.eos   = 1'b1;
            end
            default: begin
                o_emit.valid = 1'b0;
            end
        endcase
    end

    assign emit_go = o_emit.valid && i_slot_free;
    assign last_j  = r_j == (r_cnt_tot - CNT_W'(1));
    assign o_idle  = r_state == ST_IDLE;

    // sequencer
    always_comb begin
        n_state = r_state;   n_have = r_have;     n_step = r_step;   n_j = r_j;
        n_px = r_px;         n_py = r_py;         n_cx = r_cx;       n_cy = r_cy;
        n_fin = r_fin;       n_clip = r_clip;     n_xneg = r_xneg;   n_yneg = r_yneg;
        n_ax = r_ax;         n_ay = r_ay;         n_acc = r_acc;     n_sum = r_sum;
        n_mcand = r_mcand;   n_root = r_root;     n_len = r_len;     n_rem = r_rem;
        n_cnt_tot = r_cnt_tot;
        n_qx_inc = r_qx_inc; n_rx_inc = r_rx_inc; n_qy_inc = r_qy_inc; n_ry_inc = r_ry_inc;
        n_qx = r_qx;         n_rx = r_rx;         n_qy = r_qy;       n_ry = r_ry;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_cx   = i_point_x;
                    n_cy   = i_point_y;
                    n_fin  = i_final_point;
                    n_xneg = dx[DW-1];
                    n_yneg = dy[DW-1];
                    n_ax   = dx[DW-1] ? (DW'(0) - dx) : dx;
                    n_ay   = dy[DW-1] ? (DW'(0) - dy) : dy;
                    n_step = '0;
                    if (r_have) begin
                        n_acc   = {{DW{1'b0}}, n_ax};
                        n_mcand = n_ax;
                        n_state = ST_SQX;
                    end else if (i_final_point) begin
                        n_state = ST_FIN;
                    end else begin
                        n_px   = i_point_x;
                        n_py   = i_point_y;
                        n_have = 1'b1;
                    end
                end
            end
            ST_SQX: begin
                n_acc  = mul_next;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_sum   = mul_next;
                    n_acc   = {{DW{1'b0}}, r_ay};
                    n_mcand = r_ay;
                    n_step  = '0;
                    n_state = ST_SQY;
                end
            end
            ST_SQY: begin
                n_acc  = mul_next;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_acc   = r_acc + r_sum;
                n_rem   = '0;
                n_root  = '0;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                n_acc  = {r_acc[ACC_W-3:0], 2'b00};
                n_rem  = sq_rem;
                n_root = sq_root;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_len   = sq_root;
                    n_acc   = {sq_root, {DW{1'b0}}};
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = ST_CNT;
                end
            end
            ST_CNT: begin
                n_acc  = div_acc;
                n_rem  = REM_W'(div_rem);
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(CNT_STEPS - 1)) begin
                    n_step = '0;
                    n_clip = cnt_sat;
                    n_cnt_tot = cnt_sat ? CNT_W'(MAX_STEPS) : cnt_q[CNT_W-1:0];
                    if (cnt_q == '0) begin
                        n_state = ST_PREV;
                    end else begin
                        n_acc   = {{DW{1'b0}}, r_ax};
                        n_mcand = {{(DW-RES_W){1'b0}}, i_res};
                        n_state = ST_MULX;
                    end
                end
            end
            ST_MULX, ST_MULY: begin
                n_acc  = mul_next;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = (r_state == ST_MULX) ? ST_DIVX : ST_DIVY;
                end
            end
            ST_DIVX: begin
                n_acc  = div_acc;
                n_rem  = REM_W'(div_rem);
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_qx_inc = div_acc[DW-1:0];
                    n_rx_inc = div_rem[DW-1:0];
                    n_acc    = {{DW{1'b0}}, r_ay};
                    n_mcand  = {{(DW-RES_W){1'b0}}, i_res};
                    n_step   = '0;
                    n_state  = ST_MULY;
                end
            end
            ST_DIVY: begin
                n_acc  = div_acc;
                n_rem  = REM_W'(div_rem);
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_qy_inc = div_acc[DW-1:0];
                    n_ry_inc = div_rem[DW-1:0];
                    n_qx     = '0;
                    n_rx     = '0;
                    n_qy     = '0;
                    n_ry     = '0;
                    n_j      = '0;
                    n_step   = '0;
                    n_state  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    n_rx = ax_ge ? ax_red[DW-1:0] : ax_sum[DW-1:0];
                    n_qx = r_qx + r_qx_inc + DW'(ax_ge);
                    n_ry = ay_ge ? ay_red[DW-1:0] : ay_sum[DW-1:0];
                    n_qy = r_qy + r_qy_inc + DW'(ay_ge);
                    n_j  = r_j + CNT_W'(1);
                    if (last_j) begin
                        if (r_fin) begin
                            n_state = ST_FIN;
                        end else begin
                            n_px    = r_cx;
                            n_py    = r_cy;
                            n_have  = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_PREV: begin
                if (emit_go) begin
                    if (r_fin) begin
                        n_state = ST_FIN;
                    end else begin
                        n_px    = r_cx;
                        n_py    = r_cy;
                        n_have  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (emit_go) begin
                    n_px    = r_cx;
                    n_py    = r_cy;
                    n_have  = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_have  <= 1'b0;
            r_step  <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_have  <= n_have;
            r_step  <= n_step;
            r_j     <= n_j;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_px <= n_px;          r_py <= n_py;          r_cx <= n_cx;        r_cy <= n_cy;
        r_fin <= n_fin;        r_clip <= n_clip;      r_xneg <= n_xneg;    r_yneg <= n_yneg;
        r_ax <= n_ax;          r_ay <= n_ay;          r_acc <= n_acc;      r_sum <= n_sum;
        r_mcand <= n_mcand;    r_root <= n_root;      r_len <= n_len;      r_rem <= n_rem;
        r_cnt_tot <= n_cnt_tot;
        r_qx_inc <= n_qx_inc;  r_rx_inc <= n_rx_inc;  r_qy_inc <= n_qy_inc;
        r_ry_inc <= n_ry_inc;
        r_qx <= n_qx;          r_rx <= n_rx;          r_qy <= n_qy;        r_ry <= n_ry;
    end

endmodule

/* rtl/polyline_resampler.sv */
// top level of the polyline resampler: handshakes, spacing register, output register
`timescale 1ns / 1ps

// Resamples a scan polyline at a fixed spacing. Points enter one at a time and the
// block is busy while it works on a segment; every step runs on one shared
// shift-add / restoring unit, one bit (two for the square root) per cycle. A segment
// first works out the two squares, their sum, the length square root and the sample
// count; when the count is nonzero, a multiply and a divide per axis give the
// per-sample step, and the points then leave at one per cycle while the output side
// takes them. A final point also emits itself as the end-of-scan result. The output
// register lets the next point be worked on while the last result still waits.
// Write the spacing only while idle.
module polyline_resampler
    import plr_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [COORD_W-1:0] i_point_x,
    input  logic [COORD_W-1:0] i_point_y,
    input  logic               i_final_point,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COORD_W-1:0] o_out_x,
    output logic [COORD_W-1:0] o_out_y,
    output logic               o_end_of_scan,
    output logic               o_clipped,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [RES_W-1:0]   i_cfg_data
);

    logic [RES_W-1:0]   r_res;
    logic [RES_W-1:0]   res_eff;
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x, r_out_y;
    logic               r_out_eos, r_out_clip;
    logic               core_idle, slot_free;
    t_emit              emit;

    // spacing register, zero acts as one
    assign o_cfg_ready = 1'b1;
    assign res_eff     = (r_res == '0) ? RES_W'(1) : r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= RES_RESET;
        end else if (i_cfg_valid) begin
            r_res <= i_cfg_data;
        end
    end

    assign o_in_ready = core_idle;
    assign slot_free  = !r_out_valid || i_out_ready;

    plr_core #(
        .MAX_STEPS(MAX_STEPS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_in_valid && core_idle),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_final_point (i_final_point),
        .i_res         (res_eff),
        .i_slot_free   (slot_free),
        .o_idle        (core_idle),
        .o_emit        (emit)
    );

    // output register, refilled in the cycle it transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free && emit.valid) begin
            r_out_x    <= emit.x;
            r_out_y    <= emit.y;
            r_out_eos  <= emit.eos;
            r_out_clip <= emit.clip;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_end_of_scan = r_out_eos;
    assign o_clipped     = r_out_clip;

endmodule

/* sim/tb_polyline_resampler.sv */
// self-checking testbench for the polyline resampler: directed and random scans
`timescale 1ns / 1ps

module tb_polyline_resampler;
    import plr_pkg::*;

    localparam int STEP_CAP      = MAX_STEPS_DEF;
    localparam int SETTLE_CYCLES = 400;
    localparam int PHASE_POINTS  = 43;
    localparam int MAX_PRINTS    = 100;
    localparam longint LIMIT_NS  = 64'd5_000_000;

    // one resampled point as seen on the output side
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               eos;
        logic               clip;
    } t_sample;

    // tracks scan state and holds the resampled points still owed by the block
    class resample_tracker;
        logic [RES_W-1:0]          spacing;
        bit                        have_prev;
        logic signed [COORD_W-1:0] prev_x;
        logic signed [COORD_W-1:0] prev_y;
        t_sample                   pending_samples[$];
        int                        mismatches;

        function new();
            spacing    = RES_RESET;
            have_prev  = 1'b0;
            prev_x     = '0;
            prev_y     = '0;
            mismatches = 0;
        endfunction

        // floor of the square root of a 66-bit sum of squares
        function logic [33:0] floor_root(logic [65:0] v);
            logic [33:0] root;
            logic [33:0] trial;
            logic [67:0] trial_sq;
            root = '0;
            for (int b = 33; b >= 0; b--) begin
                trial    = root | (34'd1 << b);
                trial_sq = 68'(trial) * 68'(trial);
                if (trial_sq <= 68'(v)) root = trial;
            end
            return root;
        endfunction

        // d * t / len with the magnitude truncated toward zero
        function longint axis_step(longint d, longint unsigned t, logic [33:0] seg_len);
            longint unsigned mag;
            logic [127:0]    prod;
            logic [127:0]    quo;
            mag  = (d < 0) ? -d : d;
            prod = 128'(mag) * 128'(t);
            quo  = prod / 128'(seg_len);
            return (d < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        endfunction

        function void push_sample(longint x, longint y, logic eos, logic clip);
            t_sample s;
            s.x    = COORD_W'(x);
            s.y    = COORD_W'(y);
            s.eos  = eos;
            s.clip = clip;
            pending_samples.insert(pending_samples.size(), s);
        endfunction

        // accepted scan point: work out the points of the closed segment
        function void add_point(logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
                                logic fin);
            longint          dx, dy;
            logic [32:0]     ax, ay;
            logic [65:0]     sq_sum;
            logic [33:0]     seg_len;
            longint unsigned res_eff, steps;
            logic            clip;
            if (have_prev) begin
                dx      = longint'(cx) - longint'(prev_x);
                dy      = longint'(cy) - longint'(prev_y);
                ax      = 33'((dx < 0) ? -dx : dx);
                ay      = 33'((dy < 0) ? -dy : dy);
                sq_sum  = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
                seg_len = floor_root(sq_sum);
                res_eff = (spacing == 0) ? 1 : longint'(spacing);
                steps   = seg_len / res_eff;
                clip    = (steps > STEP_CAP);
                if (clip) steps = STEP_CAP;
                if (steps == 0) begin
                    push_sample(prev_x, prev_y, 1'b0, clip);
                end else begin
                    for (longint unsigned j = 0; j < steps; j++) begin
                        push_sample(longint'(prev_x) + axis_step(dx, j * res_eff, seg_len),
                                    longint'(prev_y) + axis_step(dy, j * res_eff, seg_len),
                                    1'b0, clip);
                    end
                end
            end
            prev_x    = cx;
            prev_y    = cy;
            have_prev = 1'b1;
            // a final point closes the scan and is emitted itself
            if (fin) begin
                push_sample(cx, cy, 1'b1, 1'b0);
                have_prev = 1'b0;
            end
        endfunction

        task report(string field, longint want, longint got);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("%0t mismatch on %s: expected %h, got %h", $realtime, field, want, got);
        endtask

        // output transfer: compare against the oldest owed point
        task take_sample(t_sample got);
            t_sample want;
            if (pending_samples.size() == 0) begin
                report("unexpected point x", 0, got.x);
                return;
            end
            want = pending_samples.pop_front();
            if (got.x !== want.x) report("out_x", want.x, got.x);
            if (got.y !== want.y) report("out_y", want.y, got.y);
            if (got.eos !== want.eos) report("end_of_scan", want.eos, got.eos);
            if (got.clip !== want.clip) report("clipped", want.clip, got.clip);
        endtask
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic [COORD_W-1:0] i_point_x     = '0;
    logic [COORD_W-1:0] i_point_y     = '0;
    logic               i_final_point = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic [COORD_W-1:0] o_out_x;
    logic [COORD_W-1:0] o_out_y;
    logic               o_end_of_scan;
    logic               o_clipped;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [RES_W-1:0]   i_cfg_data    = '0;

    resample_tracker sb;
    int              burst_left = 0;
    logic [9:0]      stall_cnt  = '0;

    polyline_resampler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_final_point (i_final_point),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_end_of_scan (o_end_of_scan),
        .o_clipped     (o_clipped),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver stall pattern: always ready, random, periodic, heavy random
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 10'd1;
        case (stall_cnt[9:8])
            2'd0: i_out_ready <= 1'b1;
            2'd1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2'd2: i_out_ready <= (stall_cnt[2:0] != 3'd5) && (stall_cnt[2:0] != 3'd6);
            default: i_out_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.take_sample('{x: o_out_x, y: o_out_y, eos: o_end_of_scan, clip: o_clipped});
    end

    // one input transfer, with bursts and gaps in front
    task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                              input logic fin);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(100, 500);
                default: gap = $urandom_range(1, 12);
            endcase
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_point_x     <= px;
        i_point_y     <= py;
        i_final_point <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        sb.add_point(px, py, fin);
    endtask

    // stop sending and let every owed point come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_spacing(input logic [RES_W-1:0] v);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.spacing = v;
    endtask

    // scan of mostly spacing-sized steps, with some jumps and early scan ends
    task automatic random_scan(input int n_pts);
        logic [COORD_W-1:0] px, py;
        longint             res_eff, span, dxv, dyv;
        int                 share;
        logic               fin;
        px = $urandom;
        py = $urandom;
        for (int i = 0; i < n_pts; i++) begin
            if (i > 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    px = $urandom;
                    py = $urandom;
                end else begin
                    res_eff = (sb.spacing == 0) ? 1 : longint'(sb.spacing);
                    span    = res_eff * $urandom_range(0, 68) + longint'($urandom) % res_eff;
                    share   = $urandom_range(0, 16);
                    dxv     = span * share / 16;
                    dyv     = span * (16 - share) / 16;
                    if ($urandom_range(0, 1)) dxv = -dxv;
                    if ($urandom_range(0, 1)) dyv = -dyv;
                    px = COORD_W'(longint'(px) + dxv);
                    py = COORD_W'(longint'(py) + dyv);
                end
            end
            fin = (i == n_pts - 1) || ($urandom_range(0, 29) == 0);
            send_point(px, py, fin);
        end
    endtask

    // stimulus
    initial begin
        logic [COORD_W-1:0] x, y;
        logic [RES_W-1:0]   phase_res;
        int                 count, n;
        bit                 paused;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-point scan
        send_point(32'h0, 32'h0, 1'b1);
        // extreme corners: squares overflow 64 bits, count saturates
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        // repeated point
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        // negative x steps, then exactly at the cap, then one over it
        x = 32'h7FFF_FFFF - 32'd5 * 32'd3277;
        y = 32'h8000_0000;
        send_point(x, y, 1'b0);
        x = x - 32'd63 * 32'd3277;
        send_point(x, y, 1'b0);
        x = x + 32'd64 * 32'd3277;
        send_point(x, y, 1'b0);
        // just under one spacing
        y = y + 32'd3276;
        send_point(x, y, 1'b0);
        // 3-4-5 diagonal of exactly five spacings
        x = x + 32'd9831;
        y = y + 32'd13108;
        send_point(x, y, 1'b0);
        send_point(x + 32'd100, y, 1'b1);
        // repeated point that closes the scan
        send_point(32'd5, 32'd5, 1'b0);
        send_point(32'd5, 32'd5, 1'b1);

        // smallest spacing
        write_spacing(31'd1);
        send_point(32'd0, 32'd0, 1'b0);
        send_point(32'd3, 32'd4, 1'b0);
        send_point(32'd43, 32'd4, 1'b0);
        send_point(32'hFFFF_FFD0, 32'hFFFF_FF00, 1'b1);

        // zero spacing behaves as one
        write_spacing(31'd0);
        send_point(32'd0, 32'd0, 1'b0);
        send_point(32'd6, 32'd8, 1'b0);
        send_point(32'd6, 32'd8, 1'b1);

        // largest spacing across the full coordinate range
        write_spacing(31'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);

        // random scans under several spacings
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       phase_res = RES_RESET;
                1:       phase_res = 31'd65536;
                2:       phase_res = RES_W'($urandom_range(1, 4096));
                3:       phase_res = 31'd1;
                4:       phase_res = 31'h7FFF_FFFF;
                default: phase_res = RES_W'($urandom_range(1, 1 << 24));
            endcase
            write_spacing(phase_res);
            count  = 0;
            paused = 1'b0;
            while (count < PHASE_POINTS) begin
                n = $urandom_range(1, 14);
                if (n > PHASE_POINTS - count) n = PHASE_POINTS - count;
                random_scan(n);
                count += n;
                // hold the sender until the block has emptied once per phase
                if (!paused && count > PHASE_POINTS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        if (sb.mismatches == 0 && sb.pending_samples.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // run time limit
    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
